FILE: src/cordic_atan2_and_rotate_assert.svh
// Assertion macros for the CORDIC atan2/rotate block.
// Included by the RTL files that carry concurrent checks; depends on nothing.
`ifndef CORDIC_ATAN2_AND_ROTATE_ASSERT_SVH
`define CORDIC_ATAN2_AND_ROTATE_ASSERT_SVH
`ifndef SYNTHESIS
// Check a property on the rising clock, masked while reset is asserted.
`define CORDIC_CHECK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("cordic check failed");
// Check a property on the rising clock, also during reset.
`define CORDIC_CHECK_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("cordic check failed");
`else
`define CORDIC_CHECK(label, clk, rst_n, prop)
`define CORDIC_CHECK_ALWAYS(label, clk, prop)
`endif
`endif

FILE: src/cordic_pkg.sv
// Shared types, constants and the arctangent table for the CORDIC block.
// Used by the channel interfaces, the shift-add stage and the top level.
package cordic_pkg;

    localparam int ITERATIONS_DEF = 16;
    localparam int TABLE_LEN      = 28;

    typedef logic signed [31:0] t_word;

    // Mode codes for the action field
    localparam logic ACT_VECTOR = 1'b0;
    localparam logic ACT_ROTATE = 1'b1;

    // Angles with 28 fraction bits, each a little nearer zero than the exact angle
    localparam t_word PI_POS      = 32'sd843314855;
    localparam t_word PI_NEG      = -32'sd843314856;
    localparam t_word HALF_PI_POS = 32'sd421657426;
    localparam t_word HALF_PI_NEG = -32'sd421657427;

    // floor(atan(2^-i) * 2^28)
    localparam t_word ATAN_TABLE [TABLE_LEN] = '{
        32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381289,
        32'sd16755421,  32'sd8385878,   32'sd4193962,  32'sd2097109,
        32'sd1048570,   32'sd524287,    32'sd262143,   32'sd131071,
        32'sd65535,     32'sd32767,     32'sd16383,    32'sd8191,
        32'sd4095,      32'sd2047,      32'sd1023,     32'sd511,
        32'sd255,       32'sd127,       32'sd63,       32'sd31,
        32'sd15,        32'sd7,         32'sd3,        32'sd1
    };

    typedef struct packed {
        logic  action;
        t_word x_in;
        t_word y_in;
        t_word angle_in;
    } t_in_word;

    typedef struct packed {
        t_word angle_out;
        t_word x_out;
        t_word y_out;
    } t_out_word;

    // Word carried down the pipeline: x and y with 20 fraction bits
    typedef struct packed {
        logic  action;
        t_word x;
        t_word y;
        t_word ang;
        t_word target;
    } t_stage_word;

endpackage

FILE: src/cordic_if.sv
// Valid/ready channel interfaces for the CORDIC block.
// Depends on cordic_pkg for the payload types.
interface cordic_in_if;
    logic                  valid;
    logic                  ready;
    cordic_pkg::t_in_word  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cordic_out_if;
    logic                  valid;
    logic                  ready;
    cordic_pkg::t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: src/cordic_atan2_and_rotate.sv
// CORDIC atan2 / vector rotation unit. A word is taken every cycle unless
// the pre-rotation register is full and the first stage stalls. Each word
// passes one register for the input narrowing and the plus-or-minus pi
// pre-rotation, then one register per shift-add iteration, the last of which
// drives the output. The mode is chosen per word. Rotation gain (about
// 1.64676 at 16 iterations) is not compensated, and x_out/y_out wrap. A
// stall at the output holds only the full stages with no empty stage after them.
// Depends on cordic_pkg, cordic_if, cordic_stage and the assertion header.
`include "cordic_atan2_and_rotate_assert.svh"

module cordic_atan2_and_rotate #(
    parameter int ITERATIONS = cordic_pkg::ITERATIONS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    cordic_in_if.sink       i_item,
    cordic_out_if.source    o_result
);

    logic [ITERATIONS:0]     s_valid;
    logic [ITERATIONS+1:1]   s_ready;
    cordic_pkg::t_stage_word s_data [ITERATIONS+1];

    logic                    r_valid0;
    cordic_pkg::t_stage_word r_pre;
    cordic_pkg::t_stage_word n_pre;
    cordic_pkg::t_word       x_nar;
    cordic_pkg::t_word       y_nar;
    cordic_pkg::t_word       tgt;
    cordic_pkg::t_stage_word last;

    // Narrow to 20 fraction bits and pre-rotate by plus or minus pi
    always_comb begin
        x_nar        = i_item.data.x_in >>> 2;
        y_nar        = i_item.data.y_in >>> 2;
        tgt          = i_item.data.angle_in;
        n_pre.action = i_item.data.action;
        n_pre.target = tgt;
        n_pre.x      = x_nar;
        n_pre.y      = y_nar;
        n_pre.ang    = '0;
        if (i_item.data.action == cordic_pkg::ACT_VECTOR) begin
            if (x_nar[31]) begin
                n_pre.x   = -x_nar;
                n_pre.y   = -y_nar;
                n_pre.ang = y_nar[31] ? cordic_pkg::PI_NEG : cordic_pkg::PI_POS;
            end
        end else begin
            if (tgt > cordic_pkg::HALF_PI_POS) begin
                n_pre.x   = -x_nar;
                n_pre.y   = -y_nar;
                n_pre.ang = cordic_pkg::PI_POS;
            end else if (tgt < cordic_pkg::HALF_PI_NEG) begin
                n_pre.x   = -x_nar;
                n_pre.y   = -y_nar;
                n_pre.ang = cordic_pkg::PI_NEG;
            end
        end
    end

    // Hold the pre-rotation register while the first stage is stalled
    assign i_item.ready = !r_valid0 || s_ready[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid0 <= 1'b0;
        end else if (i_item.ready) begin
            r_valid0 <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.ready && i_item.valid) begin
            r_pre <= n_pre;
        end
    end

    assign s_valid[0]            = r_valid0;
    assign s_data[0]             = r_pre;
    assign s_ready[ITERATIONS+1] = o_result.ready;

    // Shift-add iterations, one register each
    for (genvar k = 1; k <= ITERATIONS; k++) begin : g_stage
        cordic_stage #(
            .INDEX (k - 1)
        ) u_stage (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_valid      (s_valid[k-1]),
            .i_data       (s_data[k-1]),
            .o_ready      (s_ready[k]),
            .i_next_ready (s_ready[k+1]),
            .o_valid      (s_valid[k]),
            .o_data       (s_data[k])
        );
    end

    // Format the result word by mode; x and y go back to 22 fraction bits
    assign last           = s_data[ITERATIONS];
    assign o_result.valid = s_valid[ITERATIONS];

    always_comb begin
        if (last.action == cordic_pkg::ACT_ROTATE) begin
            o_result.data.angle_out = '0;
            o_result.data.x_out     = {last.x[29:0], 2'b00};
            o_result.data.y_out     = {last.y[29:0], 2'b00};
        end else begin
            o_result.data.angle_out = last.ang;
            o_result.data.x_out     = '0;
            o_result.data.y_out     = '0;
        end
    end

    // Reset empties the pipeline by the next edge
    `CORDIC_CHECK_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> s_valid == '0)
    // An accepted word lands in the pre-rotation register
    `CORDIC_CHECK(a_accept_lands, i_clk, i_rst_n,
        (i_item.valid && i_item.ready) |=> r_valid0)
    // A full pipeline with a stalled output takes no new word
    `CORDIC_CHECK(a_full_blocks, i_clk, i_rst_n,
        (&s_valid && !o_result.ready) |-> !i_item.ready)
    // Vectoring pre-rotation leaves x non-negative
    `CORDIC_CHECK(a_vector_x_pos, i_clk, i_rst_n,
        (r_valid0 && r_pre.action == cordic_pkg::ACT_VECTOR) |-> !r_pre.x[31])

endmodule

FILE: src/cordic_stage.sv
// One registered shift-add CORDIC iteration for both vectoring and rotation.
// Depends on cordic_pkg for the stage word and the arctangent table.
module cordic_stage #(
    parameter int INDEX = 0
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  cordic_pkg::t_stage_word  i_data,
    output logic                     o_ready,
    input  logic                     i_next_ready,
    output logic                     o_valid,
    output cordic_pkg::t_stage_word  o_data
);

    logic                    r_valid;
    cordic_pkg::t_stage_word r_data;
    cordic_pkg::t_stage_word n_data;
    cordic_pkg::t_word       xs;
    cordic_pkg::t_word       ys;
    logic                    up;
    logic                    ccw;
    logic                    ang_add;

    // Steer by the sign of y in vectoring, by target above angle in rotation
    always_comb begin
        xs      = i_data.x >>> INDEX;
        ys      = i_data.y >>> INDEX;
        up      = i_data.target > i_data.ang;
        ccw     = (i_data.action == cordic_pkg::ACT_ROTATE) ? up : i_data.y[31];
        ang_add = (i_data.action == cordic_pkg::ACT_ROTATE) ? up : !i_data.y[31];

        n_data        = i_data;
        n_data.x      = ccw ? i_data.x - ys : i_data.x + ys;
        n_data.y      = ccw ? i_data.y + xs : i_data.y - xs;
        n_data.ang    = ang_add ? i_data.ang + cordic_pkg::ATAN_TABLE[INDEX]
                                : i_data.ang - cordic_pkg::ATAN_TABLE[INDEX];
    end

    // Advance when this slot is empty or the next one takes the word
    assign o_ready = !r_valid || i_next_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
